// ----- rtl/smpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet encoder package
// Shared payload types and codes for the serial mouse packet encoder.
// ----------------------------------------------------------------------------
package smpe_pkg;

    localparam int MaxBytes = 6;

    localparam logic [1:0] REQ_MOTION = 2'd0;
    localparam logic [1:0] REQ_HOST   = 2'd1;
    localparam logic [1:0] REQ_RTS    = 2'd2;

    localparam logic [1:0] KIND_PACKED5 = 2'd0;
    localparam logic [1:0] KIND_SEVEN   = 2'd1;
    localparam logic [1:0] KIND_CMD     = 2'd2;

    localparam logic [0:0] CFG_DEVICE_KIND  = 1'b0;
    localparam logic [0:0] CFG_BUTTON_COUNT = 1'b1;

    localparam logic [2:0] FMT_FIVE    = 3'd0;
    localparam logic [2:0] FMT_THREE   = 3'd1;
    localparam logic [2:0] FMT_HEX     = 3'd2;
    localparam logic [2:0] FMT_RELPAD  = 3'd3;
    localparam logic [2:0] FMT_MM      = 3'd5;
    localparam logic [2:0] FMT_ABSPAD  = 3'd6;
    localparam logic [2:0] FMT_SEVEN   = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [3:0]  wheel_delta;
        logic [2:0]         button_bits;
        logic [7:0]         host_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic [1:0] rate_code;
    } t_out_item;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    endfunction

endpackage

// ----- rtl/serial_mouse_packet_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet encoder core
// Turns motion events, host command bytes and RTS toggles into mouse bytes.
// ----------------------------------------------------------------------------
// Each accepted item is decoded into a packet of up to six bytes, which is
// held in a packet buffer and sent out one byte per cycle on the result
// channel while i_ready is high, the final byte marked by last_byte. An item
// that yields no byte leaves the block idle. The next item is taken in the
// same cycle the last byte of the previous packet leaves, so packets follow
// back to back. State (format, prompt mode, rate, position, previous buttons)
// is updated when the item is accepted, so the following item sees it at once.
module serial_mouse_packet_encoder_core #(
    parameter int POS_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  smpe_pkg::t_in_item       i_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output smpe_pkg::t_out_item      o_item,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [2:0]               i_cfg_data
);

    // Wide enough for a position of up to 16 bits plus a full 16-bit delta.
    localparam int PW = 18;
    localparam logic signed [PW-1:0] PosMax = PW'((1 << POS_BITS) - 1);

    logic [1:0]          r_kind;
    logic [2:0]          r_btn_cnt;
    logic [2:0]          r_fmt;
    logic [7:0]          r_status;
    logic                r_prompt;
    logic                r_await;
    logic [2:0]          r_prev_btn;
    logic [POS_BITS-1:0] r_pos_x, r_pos_y;
    logic [1:0]          r_rate;

    logic [7:0] r_buf [smpe_pkg::MaxBytes];
    logic [2:0] r_cnt;
    logic [2:0] r_idx;

    logic [7:0] n_buf [smpe_pkg::MaxBytes];
    logic [2:0] n_cnt;
    logic [2:0] n_fmt;
    logic [7:0] n_status;
    logic       n_prompt, n_await;
    logic [2:0] n_prev_btn;
    logic [POS_BITS-1:0] n_pos_x, n_pos_y;
    logic [1:0] n_rate;

    logic accept;
    logic busy;
    logic is_last;

    // The block is busy while bytes remain; the last byte leaving frees it.
    assign busy    = (r_cnt != 3'd0);
    assign is_last = (r_idx == r_cnt - 3'd1);
    assign o_valid = busy;
    assign o_ready = !busy || (i_ready && is_last);
    assign accept  = i_valid && o_ready;

    assign o_item.tx_byte   = r_buf[r_idx];
    assign o_item.last_byte = is_last;
    assign o_item.rate_code = r_rate;

    // Clamped deltas and saturated position.
    logic signed [15:0] dx, dy;
    logic signed [11:0] cx, cy;
    logic signed [7:0]  mx, my;
    logic signed [PW-1:0] sum_x, sum_y;
    logic [2:0] b;
    logic [3:0] z;
    logic wide;

    function automatic logic signed [11:0] clamp12(input logic signed [15:0] v);
        if (v > 16'sd2047)       clamp12 = 12'sd2047;
        else if (v < -16'sd2048) clamp12 = -12'sd2048;
        else                     clamp12 = v[11:0];
    endfunction

    function automatic logic signed [7:0] clamp8(input logic signed [15:0] v);
        if (v > 16'sd127)       clamp8 = 8'sd127;
        else if (v < -16'sd128) clamp8 = -8'sd128;
        else                    clamp8 = v[7:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat(input logic signed [PW-1:0] v);
        if (v < 0)           sat = '0;
        else if (v > PosMax) sat = PosMax[POS_BITS-1:0];
        else                 sat = v[POS_BITS-1:0];
    endfunction

    always_comb begin
        dx   = i_item.delta_x;
        dy   = i_item.delta_y;
        b    = i_item.button_bits;
        z    = i_item.wheel_delta;
        wide = (r_kind >= smpe_pkg::KIND_CMD) && (r_fmt == smpe_pkg::FMT_RELPAD);
        mx   = clamp8(dx);
        my   = clamp8(dy);
        cx   = wide ? clamp12(dx) : 12'(mx);
        cy   = wide ? clamp12(dy) : 12'(my);
        sum_x = PW'($signed({1'b0, r_pos_x})) + PW'(dx);
        sum_y = PW'($signed({1'b0, r_pos_y})) + PW'(dy);
    end

    logic [7:0] mmx, mmy, ny;
    logic [13:0] ax, ay;
    logic [7:0] hdr;

    always_comb begin
        for (int k = 0; k < smpe_pkg::MaxBytes; k++) n_buf[k] = 8'h00;
        n_cnt      = 3'd0;
        n_fmt      = r_fmt;
        n_status   = r_status;
        n_prompt   = r_prompt;
        n_await    = r_await;
        n_prev_btn = r_prev_btn;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_rate     = r_rate;
        mmx = (mx < -8'sd127) ? 8'd127 : (mx < 0 ? 8'(-mx) : 8'(mx));
        mmy = (my < -8'sd127) ? 8'd127 : (my < 0 ? 8'(-my) : 8'(my));
        ny  = 8'(-cy);
        ax  = 14'(r_pos_x);
        ay  = 14'(r_pos_y);
        hdr = 8'h00;
        case (i_item.req_type)
            smpe_pkg::REQ_MOTION: begin
                if (!(dx == 0 && dy == 0 && b == r_prev_btn)) begin
                    n_pos_x    = sat(sum_x);
                    n_pos_y    = sat(sum_y);
                    n_prev_btn = b;
                    if (!r_prompt && !r_await) begin
                        if (r_kind == smpe_pkg::KIND_PACKED5 ||
                            (r_kind >= smpe_pkg::KIND_CMD &&
                             r_fmt == smpe_pkg::FMT_FIVE)) begin
                            n_buf[0] = {5'b10000, !b[0], !b[2], !b[1]};
                            n_buf[1] = cx[7:0];
                            n_buf[2] = ny;
                            n_buf[3] = cx[7:0];
                            n_buf[4] = ny;
                            n_cnt = 3'd5;
                        end else if (r_kind == smpe_pkg::KIND_SEVEN ||
                                     r_fmt == smpe_pkg::FMT_SEVEN) begin
                            n_buf[0] = {2'b01, b[0], b[1], cy[7:6], cx[7:6]};
                            n_buf[1] = {2'b00, cx[5:0]};
                            n_buf[2] = {2'b00, cy[5:0]};
                            n_cnt = 3'd3;
                            if (r_btn_cnt == 3'd3) begin
                                if (r_kind >= smpe_pkg::KIND_CMD) begin
                                    if (b[2]) begin
                                        n_buf[3] = 8'h20;
                                        n_cnt = 3'd4;
                                    end
                                end else if (b[2] != r_prev_btn[2]) begin
                                    n_cnt = 3'd4;
                                end
                            end else if (r_btn_cnt == 3'd4) begin
                                n_buf[3] = {3'b000, b[2], z};
                                n_cnt = 3'd4;
                            end
                        end else begin
                            case (r_fmt)
                                smpe_pkg::FMT_THREE: begin
                                    n_buf[0] = {5'b00000, !b[0], !b[1], !b[2]};
                                    n_buf[1] = cx[7:0];
                                    n_buf[2] = ny;
                                    n_cnt = 3'd3;
                                end
                                smpe_pkg::FMT_HEX: begin
                                    n_buf[0] = smpe_pkg::hex_char({1'b0, b[0], b[1], b[2]});
                                    n_buf[1] = smpe_pkg::hex_char(cx[3:0]);
                                    n_buf[2] = smpe_pkg::hex_char(cx[7:4]);
                                    n_buf[3] = smpe_pkg::hex_char(cy[3:0]);
                                    n_buf[4] = smpe_pkg::hex_char(cy[7:4]);
                                    n_cnt = 3'd5;
                                end
                                smpe_pkg::FMT_RELPAD, smpe_pkg::FMT_ABSPAD: begin
                                    // The relative pad sends the sign-extended
                                    // delta, the absolute pad the new position.
                                    if (r_fmt == smpe_pkg::FMT_RELPAD) begin
                                        ax = 14'(cx);
                                        ay = 14'(cy);
                                    end else begin
                                        ax = 14'(n_pos_x);
                                        ay = 14'(n_pos_y);
                                    end
                                    n_buf[0] = {3'b100, b[0], b[1], b[2], 2'b00};
                                    n_buf[1] = {2'b00, ax[5:0]};
                                    n_buf[2] = ax[13:6];
                                    n_buf[3] = {2'b00, ay[5:0]};
                                    n_buf[4] = ay[13:6];
                                    n_cnt = 3'd5;
                                end
                                smpe_pkg::FMT_MM: begin
                                    hdr = {3'b100, !mx[7], my[7], b[0], b[1], b[2]};
                                    n_buf[0] = hdr;
                                    n_buf[1] = mmx;
                                    n_buf[2] = mmy;
                                    n_cnt = 3'd3;
                                end
                                default: n_cnt = 3'd0;
                            endcase
                        end
                    end
                end
            end
            smpe_pkg::REQ_HOST: begin
                if (r_kind >= smpe_pkg::KIND_CMD) begin
                    if (r_await) begin
                        n_await = 1'b0;
                        if (i_item.host_byte >= 8'h6E && i_item.host_byte <= 8'h71)
                            n_rate = 2'(i_item.host_byte - 8'h6E);
                        else
                            n_rate = 2'd0;
                    end else begin
                        case (i_item.host_byte)
                            8'h2A: n_await = 1'b1;
                            8'h44, 8'h50: begin
                                n_prompt = 1'b1;
                                n_status = r_status | 8'h40;
                            end
                            8'h73: begin
                                n_buf[0] = r_status;
                                n_cnt = 3'd1;
                            end
                            8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h51, 8'h52: begin
                                n_prompt = 1'b0;
                                n_status = r_status & 8'hBF;
                            end
                            8'h41: begin
                                n_fmt = smpe_pkg::FMT_ABSPAD;
                                n_pos_x = '0;
                                n_pos_y = '0;
                            end
                            8'h42: n_fmt = smpe_pkg::FMT_RELPAD;
                            8'h53: n_fmt = smpe_pkg::FMT_MM;
                            8'h54: n_fmt = smpe_pkg::FMT_THREE;
                            8'h55: n_fmt = smpe_pkg::FMT_FIVE;
                            8'h56: n_fmt = smpe_pkg::FMT_SEVEN;
                            8'h57: n_fmt = smpe_pkg::FMT_HEX;
                            8'h05: n_cnt = 3'd3;
                            8'h66: begin
                                n_buf[0] = {3'b000, 1'b1, r_fmt, 1'b0};
                                n_cnt = 3'd1;
                            end
                            default: n_cnt = 3'd0;
                        endcase
                    end
                end
            end
            smpe_pkg::REQ_RTS: begin
                if (r_kind == smpe_pkg::KIND_PACKED5) begin
                    n_buf[0] = 8'h48;
                    n_cnt = 3'd1;
                end else if (r_btn_cnt == 3'd3) begin
                    n_buf[0] = 8'h4D;
                    n_buf[1] = 8'h33;
                    n_cnt = 3'd2;
                end else if (r_btn_cnt == 3'd4) begin
                    n_buf[0] = 8'h4D;
                    n_buf[1] = 8'h5A;
                    n_buf[2] = 8'h40;
                    n_cnt = 3'd6;
                end else begin
                    n_buf[0] = 8'h4D;
                    n_cnt = 3'd1;
                end
            end
            default: n_cnt = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= smpe_pkg::KIND_SEVEN;
            r_btn_cnt  <= 3'd2;
            r_fmt      <= smpe_pkg::FMT_SEVEN;
            r_status   <= 8'h0F;
            r_prompt   <= 1'b0;
            r_await    <= 1'b0;
            r_prev_btn <= 3'd0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_rate     <= 2'd0;
            r_cnt      <= 3'd0;
            r_idx      <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == smpe_pkg::CFG_DEVICE_KIND) r_kind <= i_cfg_data[1:0];
                else                                          r_btn_cnt <= i_cfg_data;
            end
            if (accept) begin
                r_fmt      <= n_fmt;
                r_status   <= n_status;
                r_prompt   <= n_prompt;
                r_await    <= n_await;
                r_prev_btn <= n_prev_btn;
                r_pos_x    <= n_pos_x;
                r_pos_y    <= n_pos_y;
                r_rate     <= n_rate;
                r_cnt      <= n_cnt;
                r_idx      <= 3'd0;
            end else if (busy && i_ready) begin
                // The last byte leaving with no new item empties the buffer.
                if (is_last) begin
                    r_cnt <= 3'd0;
                    r_idx <= 3'd0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < smpe_pkg::MaxBytes; k++) r_buf[k] <= n_buf[k];
        end
    end

endmodule
